FILE: rtl/core/abpp_pkg.sv
// Shared types, constants and helpers of the alpha blend pixel packer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package abpp_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_LANE_MODE = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_OFFSET     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_OFFSET   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_OFFSET    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_BITS       = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_BITS     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_BITS      = 4'd7;

    // Pixel format codes; any other code packs as 32bpp
    localparam logic [1:0] FMT_16BPP = 2'd0;
    localparam logic [1:0] FMT_24BPP = 2'd1;
    localparam logic [1:0] FMT_32BPP = 2'd2;

    localparam logic [31:0] MASK_16BPP = 32'h0000_ffff;
    localparam logic [31:0] MASK_24BPP = 32'h00ff_ffff;

    // Dither phase loaded at the start of a row
    localparam logic [1:0] PHASE_ODD_ROW  = 2'd1;
    localparam logic [1:0] PHASE_EVEN_ROW = 2'd3;
    localparam logic [1:0] PHASE_TOGGLE   = 2'd3;

    typedef struct packed {
        logic [1:0] pixel_format;
        logic       byte_lane_mode;
        logic [4:0] red_offset;
        logic [4:0] green_offset;
        logic [4:0] blue_offset;
        logic [3:0] red_bits;
        logic [3:0] green_bits;
        logic [3:0] blue_bits;
    } cfg_t;

    // Clamp a field width to 1..8
    function automatic logic [3:0] eff_bits(input logic [3:0] n);
        logic [3:0] r;
        if (n == 4'd0)
            r = 4'd1;
        else if (n > 4'd8)
            r = 4'd8;
        else
            r = n;
        return r;
    endfunction

    // Extract an n-bit field at off and widen it to 8 bits (n is 1..8)
    function automatic logic [7:0] unpack_chan(input logic [31:0] word,
                                               input logic [4:0]  off,
                                               input logic [3:0]  n);
        logic [31:0] shifted;
        logic [7:0]  mask;
        logic [7:0]  field;
        logic [3:0]  sh;
        shifted = word >> off;
        sh      = 4'd8 - n;
        mask    = 8'hff >> sh;
        field   = shifted[7:0] & mask;
        return 8'(field << sh);
    endfunction

    // Byte of the word that a lane offset selects (offset / 8)
    function automatic logic [7:0] lane_byte(input logic [31:0] word,
                                             input logic [4:0]  off);
        logic [31:0] shifted;
        shifted = word >> {off[4:3], 3'b000};
        return shifted[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/abpp_if.sv
// Channel interfaces of the alpha blend pixel packer: pixel in, packed
// word out and configuration write. Depends on abpp_pkg.
`default_nettype none

interface abpp_pix_if;
    logic        valid;
    logic        ready;
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] background;
    logic        has_alpha;
    logic        row_start;
    logic        row_odd;

    modport source (output valid, alpha, red, green, blue, background,
                    has_alpha, row_start, row_odd, input ready);
    modport sink   (input valid, alpha, red, green, blue, background,
                    has_alpha, row_start, row_odd, output ready);
endinterface

interface abpp_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel;

    modport source (output valid, pixel, input ready);
    modport sink   (input valid, pixel, output ready);
endinterface

interface abpp_cfg_if
    import abpp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/alpha_blend_pixel_packer_unit.sv
// Top level of the alpha blend pixel packer: input register, three channel
// blenders, pack/merge logic and result register. Depends on abpp_pkg,
// abpp_if, abpp_cfg_regs and abpp_blend.
`default_nettype none

// Blends one 8-bit RGBA source pixel over a background framebuffer word and
// returns the new word, packed as 16, 24 or 32bpp by per-channel offset and
// bit count, or in byte-lane mode with three whole bytes replaced in place
// (byte position = offset/8, blue wins over green, green over red on a
// shared byte). In normal-mode 16bpp a 2x2 ordered dither is added before
// truncation; its phase reloads on row_start (odd row 1, even row 3) and
// toggles on every transfer in every mode. Throughput is one pixel per
// clock with no stall of its own; the result is offered through two
// register stages: the input register holds the unpacked background
// channels, the result register holds the packed word, and the blend
// multiply, divide-by-255 and pack sit between them. An output hold on the
// word channel stalls the input channel in the same cycle once both
// registers are full. Configuration writes are taken in every cycle and
// must only happen while the block is idle.
module alpha_blend_pixel_packer_unit
    import abpp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    abpp_cfg_if.sink    cfg,
    abpp_pix_if.sink    pix,
    abpp_word_if.source word
);

    typedef struct packed {
        logic [7:0]  alpha;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  bg_red;
        logic [7:0]  bg_green;
        logic [7:0]  bg_blue;
        logic [31:0] background;
        logic [1:0]  d;
    } stage_t;

    cfg_t        regs;
    logic [3:0]  red_n;
    logic [3:0]  green_n;
    logic [3:0]  blue_n;

    logic        in_vld_reg;
    logic        in_vld_next;
    stage_t      in_reg;
    stage_t      in_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        out_vld_reg;
    logic        out_vld_next;
    logic [31:0] out_pixel_reg;
    logic [31:0] out_pixel_next;

    logic        out_adv;
    logic        in_adv;
    logic        in_xfer;
    logic [31:0] bg_masked;
    logic        dither_on;
    logic [2:0]  dith_rb;
    logic [2:0]  dith_g;
    logic [7:0]  t_red;
    logic [7:0]  t_green;
    logic [7:0]  t_blue;
    logic [31:0] norm_word;
    logic [31:0] lane_word;

    abpp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign red_n   = eff_bits(regs.red_bits);
    assign green_n = eff_bits(regs.green_bits);
    assign blue_n  = eff_bits(regs.blue_bits);

    // Handshake: the result register advances when empty or taken, the
    // input register advances when empty or draining into the result.
    assign out_adv    = !out_vld_reg || word.ready;
    assign in_adv     = !in_vld_reg || out_adv;
    assign pix.ready  = in_adv;
    assign in_xfer    = pix.valid && in_adv;
    assign word.valid = out_vld_reg;
    assign word.pixel = out_pixel_reg;

    // Input side: effective alpha, dither phase and unpacked background
    always_comb
    begin
        case (regs.pixel_format)
            FMT_16BPP: bg_masked = pix.background & MASK_16BPP;
            FMT_24BPP: bg_masked = pix.background & MASK_24BPP;
            default:   bg_masked = pix.background;
        endcase

        in_next.alpha      = pix.has_alpha ? pix.alpha : 8'hff;
        in_next.red        = pix.red;
        in_next.green      = pix.green;
        in_next.blue       = pix.blue;
        in_next.background = pix.background;

        if (pix.row_start)
            in_next.d = pix.row_odd ? PHASE_ODD_ROW : PHASE_EVEN_ROW;
        else
            in_next.d = phase_reg;

        if (regs.byte_lane_mode)
        begin
            in_next.bg_red   = lane_byte(pix.background, regs.red_offset);
            in_next.bg_green = lane_byte(pix.background, regs.green_offset);
            in_next.bg_blue  = lane_byte(pix.background, regs.blue_offset);
        end
        else
        begin
            in_next.bg_red   = unpack_chan(bg_masked, regs.red_offset, red_n);
            in_next.bg_green = unpack_chan(bg_masked, regs.green_offset, green_n);
            in_next.bg_blue  = unpack_chan(bg_masked, regs.blue_offset, blue_n);
        end

        phase_next  = in_xfer ? (in_next.d ^ PHASE_TOGGLE) : phase_reg;
        in_vld_next = in_adv ? pix.valid : in_vld_reg;
    end

    // Dither only in normal-mode 16bpp: red and blue get 2d+1, green gets d
    assign dither_on = !regs.byte_lane_mode && (regs.pixel_format == FMT_16BPP);
    assign dith_rb   = dither_on ? {in_reg.d, 1'b1} : 3'd0;
    assign dith_g    = dither_on ? {1'b0, in_reg.d} : 3'd0;

    abpp_blend u_blend_red (
        .bg     (in_reg.bg_red),
        .color  (in_reg.red),
        .alpha  (in_reg.alpha),
        .dither (dith_rb),
        .result (t_red)
    );

    abpp_blend u_blend_green (
        .bg     (in_reg.bg_green),
        .color  (in_reg.green),
        .alpha  (in_reg.alpha),
        .dither (dith_g),
        .result (t_green)
    );

    abpp_blend u_blend_blue (
        .bg     (in_reg.bg_blue),
        .color  (in_reg.blue),
        .alpha  (in_reg.alpha),
        .dither (dith_rb),
        .result (t_blue)
    );

    // Result side: truncate and pack, or merge bytes into the background
    always_comb
    begin
        logic [7:0]  tr;
        logic [7:0]  tg;
        logic [7:0]  tb;
        logic [31:0] packed_word;
        logic [7:0]  bg_byte;
        logic [1:0]  k;

        tr = t_red   >> (4'd8 - red_n);
        tg = t_green >> (4'd8 - green_n);
        tb = t_blue  >> (4'd8 - blue_n);

        // Bits shifted past bit 31 drop off
        packed_word = ({24'b0, tr} << regs.red_offset)
                    | ({24'b0, tg} << regs.green_offset)
                    | ({24'b0, tb} << regs.blue_offset);

        case (regs.pixel_format)
            FMT_16BPP: norm_word = packed_word & MASK_16BPP;
            FMT_24BPP: norm_word = packed_word & MASK_24BPP;
            default:   norm_word = packed_word;
        endcase

        lane_word = in_reg.background;
        for (int i = 0; i < 4; i++)
        begin
            k       = 2'(i);
            bg_byte = in_reg.background[i*8 +: 8];
            if (regs.blue_offset[4:3] == k)
                lane_word[i*8 +: 8] = t_blue;
            else if (regs.green_offset[4:3] == k)
                lane_word[i*8 +: 8] = t_green;
            else if (regs.red_offset[4:3] == k)
                lane_word[i*8 +: 8] = t_red;
            else
                lane_word[i*8 +: 8] = bg_byte;
        end

        out_pixel_next = regs.byte_lane_mode ? lane_word : norm_word;
        out_vld_next   = out_adv ? in_vld_reg : out_vld_reg;
    end

    // Control state: valid flags and dither phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= 2'd0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            phase_reg   <= phase_next;
        end
    end

    // Payload: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_reg <= in_next;
        if (out_adv && in_vld_reg)
            out_pixel_reg <= out_pixel_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/abpp_cfg_regs.sv
// Configuration register file of the alpha blend pixel packer.
// Depends on abpp_pkg and abpp_if.
`default_nettype none

module abpp_cfg_regs
    import abpp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    abpp_cfg_if.sink  cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PIXEL_FORMAT:   regs_next.pixel_format   = cfg.data[1:0];
                CFG_BYTE_LANE_MODE: regs_next.byte_lane_mode = cfg.data[0];
                CFG_RED_OFFSET:     regs_next.red_offset     = cfg.data[4:0];
                CFG_GREEN_OFFSET:   regs_next.green_offset   = cfg.data[4:0];
                CFG_BLUE_OFFSET:    regs_next.blue_offset    = cfg.data[4:0];
                CFG_RED_BITS:       regs_next.red_bits       = cfg.data[3:0];
                CFG_GREEN_BITS:     regs_next.green_bits     = cfg.data[3:0];
                CFG_BLUE_BITS:      regs_next.blue_bits      = cfg.data[3:0];
                default:            regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.pixel_format   <= FMT_16BPP;
            regs_reg.byte_lane_mode <= 1'b0;
            regs_reg.red_offset     <= 5'd11;
            regs_reg.green_offset   <= 5'd5;
            regs_reg.blue_offset    <= 5'd0;
            regs_reg.red_bits       <= 4'd5;
            regs_reg.green_bits     <= 4'd6;
            regs_reg.blue_bits      <= 4'd5;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/abpp_blend.sv
// One channel of the blender: (bg*(255-a) + c*a)/255, then an optional
// dither add that saturates at 255. Depends on abpp_pkg.
`default_nettype none

module abpp_blend
    import abpp_pkg::*;
(
    input  wire logic [7:0] bg,
    input  wire logic [7:0] color,
    input  wire logic [7:0] alpha,
    input  wire logic [2:0] dither,
    output logic      [7:0] result
);

    logic [15:0] prod;
    logic [16:0] quot_sum;
    logic [7:0]  quot;
    logic [8:0]  dith_sum;

    always_comb
    begin
        // Widen both factors so each product keeps all 16 bits
        prod = ({8'b0, bg} * {8'b0, 8'd255 - alpha}) + ({8'b0, color} * {8'b0, alpha});
        // Exact x/255 for x up to 255*255: (x + x/256 + 1) / 256
        quot_sum = {1'b0, prod} + {9'b0, prod[15:8]} + 17'd1;
        quot     = quot_sum[15:8];
        dith_sum = {1'b0, quot} + {6'b0, dither};
        result   = dith_sum[8] ? 8'hff : dith_sum[7:0];
    end

endmodule

`default_nettype wire
